### design/alp_pkg.sv
// Shared types, widths and helpers for the associated Legendre evaluator.
// Used by every cell module and by the top level; depends on nothing.
package alp_pkg;

    localparam int LMAX_DEF = 8;

    localparam int XW    = 32;   // argument x, signed Q2.30
    localparam int VW    = 56;   // values, signed Q26.30
    localparam int BW    = 37;   // second multiplier operand, signed
    localparam int SW    = 31;   // square root, unsigned Q.30
    localparam int RW    = 63;   // radicand and root remainder
    localparam int CW    = 5;    // small integer coefficients
    localparam int DW    = 4;    // divisor k - m
    localparam int UW    = 64;   // dividend magnitude
    localparam int DSTEP = 8;    // quotient bits per divider stage

    localparam int CFG_IW = 8;
    localparam int CFG_DW = 32;
    localparam logic [CFG_IW-1:0] IDX_DEGREE = 8'd0;
    localparam logic [CFG_IW-1:0] IDX_ORDER  = 8'd1;

    localparam logic signed [VW-1:0] VMAX    = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN    = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] ONE_Q30 = 56'sd1073741824;
    localparam logic [63:0] MAG_MAX = 64'h007F_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAG_MIN = 64'h0080_0000_0000_0000;
    localparam logic [RW-1:0] ONE_Q60 = 63'h1000_0000_0000_0000;

    typedef struct packed {
        logic                 valid;
        logic signed [XW-1:0] x;
        logic [RW-1:0]        rem;
        logic [SW-1:0]        root;
    } t_sq;

    typedef struct packed {
        logic                 valid;
        logic signed [XW-1:0] x;
        logic [SW-1:0]        s;
        logic signed [VW-1:0] pmm;
    } t_pm;

    typedef struct packed {
        logic                 valid;
        logic signed [XW-1:0] x;
        logic signed [VW-1:0] a;
        logic signed [VW-1:0] b;
    } t_rc;

    // Applies a sign to a magnitude and saturates to the value range.
    function automatic logic signed [VW-1:0] sat_mag(input logic neg, input logic [63:0] mag);
        logic [63:0] nm;
        nm = ~mag + 64'd1;
        if (neg) begin
            sat_mag = (mag > MAG_MIN) ? VMIN : $signed(nm[VW-1:0]);
        end else begin
            sat_mag = (mag > MAG_MAX) ? VMAX : $signed(mag[VW-1:0]);
        end
    endfunction

endpackage

### design/alp_mulq.sv
// Two-stage Q.30 multiplier with round half away from zero and saturation.
// Depends on alp_pkg.
module alp_mulq (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [alp_pkg::VW-1:0]          i_a,
    input  logic signed [alp_pkg::BW-1:0]          i_b,
    output logic signed [alp_pkg::VW-1:0]          o_p
);
    localparam int HW   = alp_pkg::VW / 2;
    localparam int PW   = HW + alp_pkg::BW;
    localparam int SUMW = PW + HW;

    logic [alp_pkg::VW-1:0] ua;
    logic [alp_pkg::BW-1:0] ub;
    logic [PW-1:0]          r_p0, r_p1;
    logic                   r_neg;
    logic [SUMW-1:0]        sum;
    logic signed [alp_pkg::VW-1:0] r_p;

    assign ua  = i_a[alp_pkg::VW-1] ? (~i_a + 1'b1) : i_a;
    assign ub  = i_b[alp_pkg::BW-1] ? (~i_b + 1'b1) : i_b;
    assign sum = {{HW{1'b0}}, r_p0} + {r_p1, {HW{1'b0}}} + (SUMW'(1) << 29);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0  <= PW'(ua[HW-1:0]) * PW'(ub);
            r_p1  <= PW'(ua[alp_pkg::VW-1:HW]) * PW'(ub);
            r_neg <= i_a[alp_pkg::VW-1] ^ i_b[alp_pkg::BW-1];
            r_p   <= alp_pkg::sat_mag(r_neg, 64'(sum[SUMW-1:30]));
        end
    end

    assign o_p = r_p;
endmodule

### design/alp_sqrt_cell.sv
// One bit of the pipelined integer square root of the radicand.
// Depends on alp_pkg.
module alp_sqrt_cell #(
    parameter int B = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  alp_pkg::t_sq  i_d,
    output alp_pkg::t_sq  o_d
);
    alp_pkg::t_sq r_q, n_q;
    logic [alp_pkg::RW-1:0] inc;
    logic ge;

    always_comb begin
        inc = (alp_pkg::RW'(i_d.root) << (B + 1)) + (alp_pkg::RW'(1) << (2 * B));
        ge  = i_d.rem >= inc;
        n_q = i_d;
        if (ge) begin
            n_q.rem  = i_d.rem - inc;
            n_q.root = i_d.root | (alp_pkg::SW'(1) << B);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_d = r_q;
endmodule

### design/alp_pmm_cell.sv
// One factor of P_m^m: multiplies by -(2i-1) s when i does not exceed the order.
// Depends on alp_pkg and alp_mulq.
module alp_pmm_cell #(
    parameter int I = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [alp_pkg::DW-1:0]    i_m,
    input  alp_pkg::t_pm              i_d,
    output alp_pkg::t_pm              o_d
);
    logic [alp_pkg::BW-1:0]        cb;
    logic signed [alp_pkg::VW-1:0] prod, negp;
    alp_pkg::t_pm r_d1, r_d2, r_q;
    logic use_it;

    assign cb     = alp_pkg::BW'(i_d.s) * alp_pkg::BW'(2 * I - 1);
    assign negp   = (prod == alp_pkg::VMIN) ? alp_pkg::VMAX : -prod;
    assign use_it = {1'b0, i_m} >= alp_pkg::CW'(I);

    alp_mulq u_mul (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_d.pmm),
        .i_b   ($signed(cb)),
        .o_p   (prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1.valid <= 1'b0;
            r_d2.valid <= 1'b0;
            r_q.valid  <= 1'b0;
        end else if (i_en) begin
            r_d1 <= i_d;
            r_d2 <= r_d1;
            r_q  <= r_d2;
            if (use_it) begin
                r_q.pmm <= negp;
            end
        end
    end

    assign o_d = r_q;
endmodule

### design/alp_rec_cell.sv
// One degree step of the upward recurrence, with a digit-pipelined divide by k - m.
// Depends on alp_pkg and alp_mulq.
module alp_rec_cell #(
    parameter int K = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [alp_pkg::DW-1:0]    i_m,
    input  logic [alp_pkg::DW-1:0]    i_l,
    input  alp_pkg::t_rc              i_d,
    output alp_pkg::t_rc              o_d
);
    localparam int T2W = alp_pkg::VW + alp_pkg::CW + 1;
    localparam int NDS = alp_pkg::UW / alp_pkg::DSTEP;

    logic [alp_pkg::CW-1:0]        kk, mm, c2, dd;
    logic                          active;
    logic [alp_pkg::DW-1:0]        d_div;
    logic signed [alp_pkg::BW-1:0] ax;
    logic signed [T2W-1:0]         t2_n, num;
    logic [T2W-1:0]                mg;
    logic signed [alp_pkg::VW-1:0] prod, res;

    alp_pkg::t_rc r_d1, r_d2, r_q;
    logic signed [T2W-1:0] r_t2a, r_t2b;

    alp_pkg::t_rc           r_s [0:NDS];
    logic [alp_pkg::UW-1:0] r_u [0:NDS];
    logic [alp_pkg::UW-1:0] r_qt [0:NDS];
    logic [alp_pkg::DW-1:0] r_rem [0:NDS];
    logic                   r_neg [0:NDS];
    logic [alp_pkg::UW-1:0] n_u [1:NDS];
    logic [alp_pkg::UW-1:0] n_qt [1:NDS];
    logic [alp_pkg::DW-1:0] n_rem [1:NDS];

    // The user must keep configuration static while items are in flight; the block does not enforce it.
    assign kk     = alp_pkg::CW'(K);
    assign mm     = {1'b0, i_m};
    assign active = (mm < kk) && (kk <= {1'b0, i_l});
    assign dd     = kk - mm;
    assign d_div  = active ? dd[alp_pkg::DW-1:0] : alp_pkg::DW'(1);
    assign c2     = kk + mm - alp_pkg::CW'(1);

    assign ax   = alp_pkg::BW'(i_d.x) * $signed(alp_pkg::BW'(2 * K - 1));
    assign t2_n = T2W'(i_d.a) * $signed({1'b0, c2});
    assign num  = T2W'(prod) - r_t2b;
    assign mg   = num[T2W-1] ? (~num + 1'b1) : num;

    alp_mulq u_mul (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_d.b),
        .i_b   (ax),
        .o_p   (prod)
    );

    // Restoring division, one quotient bit per step, DSTEP steps per stage.
    always_comb begin
        logic [alp_pkg::DW:0]   t;
        logic [alp_pkg::UW-1:0] u, q;
        logic [alp_pkg::DW-1:0] rm;
        for (int j = 0; j < NDS; j++) begin
            u  = r_u[j];
            q  = r_qt[j];
            rm = r_rem[j];
            for (int b = 0; b < alp_pkg::DSTEP; b++) begin
                t = {rm, u[alp_pkg::UW-1]};
                u = u << 1;
                if (t >= {1'b0, d_div}) begin
                    t = t - {1'b0, d_div};
                    q = {q[alp_pkg::UW-2:0], 1'b1};
                end else begin
                    q = {q[alp_pkg::UW-2:0], 1'b0};
                end
                rm = t[alp_pkg::DW-1:0];
            end
            n_u[j+1]   = u;
            n_qt[j+1]  = q;
            n_rem[j+1] = rm;
        end
    end

    assign res = alp_pkg::sat_mag(r_neg[NDS], r_qt[NDS]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1.valid <= 1'b0;
            r_d2.valid <= 1'b0;
            r_q.valid  <= 1'b0;
            for (int j = 0; j <= NDS; j++) begin
                r_s[j].valid <= 1'b0;
            end
        end else if (i_en) begin
            r_d1  <= i_d;
            r_d2  <= r_d1;
            r_t2a <= t2_n;
            r_t2b <= r_t2a;
            r_s[0]   <= r_d2;
            r_u[0]   <= alp_pkg::UW'(mg) + alp_pkg::UW'(d_div >> 1);
            r_qt[0]  <= '0;
            r_rem[0] <= '0;
            r_neg[0] <= num[T2W-1];
            for (int j = 1; j <= NDS; j++) begin
                r_s[j]   <= r_s[j-1];
                r_neg[j] <= r_neg[j-1];
                r_u[j]   <= n_u[j];
                r_qt[j]  <= n_qt[j];
                r_rem[j] <= n_rem[j];
            end
            r_q <= r_s[NDS];
            if (active) begin
                r_q.a <= r_s[NDS].b;
                r_q.b <= res;
            end
        end
    end

    assign o_d = r_q;
endmodule

### design/associated_legendre_eval_unit.sv
// Associated Legendre evaluator P_l^m(x), Condon-Shortley sign, Q2.30 in, Q26.30 out.
// Pipeline: one radicand stage, 31 square-root cells, the P_m^m cells, the recurrence
// cells and one output register.
// Throughput: one transaction per cycle while the output is not stalled; every cell is a fully pipelined stage.
// Reset (synchronous, active low) clears all valid bits and sets degree and order to 0.
// Depends on alp_pkg, alp_sqrt_cell, alp_pmm_cell, alp_rec_cell and alp_mulq.
module associated_legendre_eval_unit #(
    parameter int LMAX = alp_pkg::LMAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [alp_pkg::XW-1:0] i_arg_x,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [alp_pkg::VW-1:0] o_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [alp_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [alp_pkg::CFG_DW-1:0]    i_cfg_data
);
    // The whole row of cells advances together. It only holds when a finished
    // result sits in the output register and the downstream side stalls it.
    logic en;
    logic [alp_pkg::DW-1:0] r_degree, r_order, l_eff;
    logic [alp_pkg::XW-1:0] ux;
    logic [63:0]            x2;
    alp_pkg::t_sq           r_a;
    logic                   r_ovalid;
    logic signed [alp_pkg::VW-1:0] r_value;

    alp_pkg::t_sq sq [0:alp_pkg::SW];
    alp_pkg::t_pm pm [0:LMAX];
    alp_pkg::t_rc rc [0:LMAX];

    assign en          = !(r_ovalid && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_value     = r_value;

    // Degrees above the built maximum behave as the maximum.
    assign l_eff = (r_degree > alp_pkg::DW'(LMAX)) ? alp_pkg::DW'(LMAX) : r_degree;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= '0;
            r_order  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                alp_pkg::IDX_DEGREE: r_degree <= i_cfg_data[alp_pkg::DW-1:0];
                alp_pkg::IDX_ORDER:  r_order  <= i_cfg_data[alp_pkg::DW-1:0];
                default: ;
            endcase
        end
    end

    // Radicand 1 - x^2 in Q.60, clamped at zero for arguments outside [-1, 1].
    assign ux = i_arg_x[alp_pkg::XW-1] ? (~i_arg_x + 1'b1) : i_arg_x;
    assign x2 = 64'(ux) * 64'(ux);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
        end else if (en) begin
            r_a.valid <= i_valid;
            r_a.x     <= i_arg_x;
            r_a.root  <= '0;
            r_a.rem   <= (x2 >= 64'(alp_pkg::ONE_Q60)) ? '0 : alp_pkg::ONE_Q60 - x2[alp_pkg::RW-1:0];
        end
    end

    assign sq[0] = r_a;

    // Square root, most significant bit first, one bit per cell.
    for (genvar j = 0; j < alp_pkg::SW; j++) begin : g_sqrt
        alp_sqrt_cell #(.B(alp_pkg::SW - 1 - j)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_d     (sq[j]),
            .o_d     (sq[j+1])
        );
    end

    always_comb begin
        pm[0].valid = sq[alp_pkg::SW].valid;
        pm[0].x     = sq[alp_pkg::SW].x;
        pm[0].s     = sq[alp_pkg::SW].root;
        pm[0].pmm   = alp_pkg::ONE_Q30;
    end

    // P_m^m: cell i applies the factor -(2i-1) s when i is at most the order.
    for (genvar j = 0; j < LMAX; j++) begin : g_pmm
        alp_pmm_cell #(.I(j + 1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_m     (r_order),
            .i_d     (pm[j]),
            .o_d     (pm[j+1])
        );
    end

    // The recurrence starts with P_{m-1} = 0 and P_m = P_m^m, so the first
    // active cell (k = m + 1) yields x (2m+1) P_m^m with no special case.
    always_comb begin
        rc[0].valid = pm[LMAX].valid;
        rc[0].x     = pm[LMAX].x;
        rc[0].a     = '0;
        rc[0].b     = pm[LMAX].pmm;
    end

    for (genvar j = 0; j < LMAX; j++) begin : g_rec
        alp_rec_cell #(.K(j + 1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_m     (r_order),
            .i_l     (l_eff),
            .i_d     (rc[j]),
            .o_d     (rc[j+1])
        );
    end

    // An order larger than the degree gives zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_ovalid <= rc[LMAX].valid;
            r_value  <= (r_order > l_eff) ? '0 : rc[LMAX].b;
        end
    end
endmodule

### tb/sv/associated_legendre_eval_unit_tb.sv
// Self-checking testbench for associated_legendre_eval_unit (P_l^m(x), Q2.30 in, Q26.30 out).
// Depends on alp_pkg and the block itself; a bit-exact predictor runs alongside the block.
`timescale 1ns / 1ps

module associated_legendre_eval_unit_tb;

    // The drain below waits longer than the block takes end to end at the default
    // maximum degree before it touches the registers.
    localparam int PIPE_WAIT = 170;
    localparam logic [alp_pkg::CFG_IW-1:0] IDX_UNUSED = 8'd5;
    localparam int N_RANDOM = 1030;
    localparam logic signed [63:0] V_HI = 64'sd36028797018963967;
    localparam logic signed [63:0] V_LO = -64'sd36028797018963968;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic signed [alp_pkg::XW-1:0] i_arg_x = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic signed [alp_pkg::VW-1:0] o_value;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [alp_pkg::CFG_IW-1:0]    i_cfg_index = '0;
    logic [alp_pkg::CFG_DW-1:0]    i_cfg_data = '0;

    associated_legendre_eval_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_arg_x    (i_arg_x),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_value    (o_value),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Local copy of the two configuration registers, as the block should hold them.
    logic [3:0] deg_reg = 4'd0;
    logic [3:0] ord_reg = 4'd0;

    // Values still owed by the block, oldest first.
    logic signed [alp_pkg::VW-1:0] owed_values[$];
    int error_count = 0;

    // Idling odds in percent for the sending and the receiving side.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------
    function automatic logic signed [63:0] clamp_value(input logic signed [63:0] v);
        if (v > V_HI) return V_HI;
        if (v < V_LO) return V_LO;
        return v;
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // Q.30 product, rounded half away from zero, then saturated.
    function automatic logic signed [63:0] q30_product(input logic signed [63:0] a,
                                                        input logic signed [63:0] b);
        logic         neg;
        logic [127:0] p;
        logic [63:0]  mag;
        neg = (a < 0) != (b < 0);
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        p = p + (128'd1 << 29);
        if (p[127:94] != 0) mag = 64'd1 << 62;
        else mag = p[93:30];
        if (neg) begin
            if (mag > (64'd1 << 55)) return V_LO;
            return -$signed(mag);
        end
        if (mag > 64'(V_HI)) return V_HI;
        return $signed(mag);
    endfunction

    // Division by a small positive integer, rounded half away from zero.
    function automatic logic signed [63:0] round_divide(input logic signed [63:0] num,
                                                         input logic [63:0] d);
        logic [63:0] q;
        q = (magnitude(num) + d / 2) / d;
        if (q > (64'd1 << 60)) q = 64'd1 << 60;
        return clamp_value(num < 0 ? -$signed(q) : $signed(q));
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] r);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > r) bitv >>= 2;
        while (bitv != 0) begin
            if (r >= res + bitv) begin
                r = r - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // P_l^m(x) with the Condon-Shortley sign, for the current register settings.
    function automatic logic signed [alp_pkg::VW-1:0] legendre_value(
        input logic signed [alp_pkg::XW-1:0] arg);
        logic signed [63:0] x, l, m, p_low, p_mid, p_top, s, t1, t2;
        logic [63:0]        x2, rad;
        x = arg;
        l = (deg_reg > alp_pkg::LMAX_DEF) ? alp_pkg::LMAX_DEF : deg_reg;
        m = ord_reg;
        p_low = 64'sd1 << 30;
        if (m > l) return '0;
        if (m > 0) begin
            x2 = magnitude(x) * magnitude(x);
            rad = (x2 >= (64'd1 << 60)) ? 64'd0 : (64'd1 << 60) - x2;
            s = $signed(floor_sqrt(rad));
            for (int i = 1; i <= m; i++)
                p_low = clamp_value(-q30_product(p_low, s * (2 * i - 1)));
        end
        if (l == m) return p_low[alp_pkg::VW-1:0];
        p_mid = q30_product(x * (2 * m + 1), p_low);
        p_top = p_mid;
        for (int k = m + 2; k <= l; k++) begin
            t1 = q30_product(x * (2 * k - 1), p_mid);
            t2 = (k + m - 1) * p_low;
            p_top = round_divide(t1 - t2, k - m);
            p_low = p_mid;
            p_mid = p_top;
        end
        return p_top[alp_pkg::VW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Result side: checks every accepted result and stalls at random.
    // Sampling happens before this edge's updates, so the stall seen here
    // is the one the block saw.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic signed [alp_pkg::VW-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (owed_values.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d", o_value));
            end else begin
                want = owed_values.pop_front();
                if (o_value !== want)
                    report_mismatch($sformatf("value %0d, expected %0d", o_value, want));
            end
        end
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Stops sending, then waits until every owed value has come back and the
    // pipeline is empty.
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (owed_values.size() != 0) @(posedge i_clk);
        repeat (PIPE_WAIT) @(posedge i_clk);
    endtask

    // Leaves the write channel valid; the caller drops it after its last write.
    task automatic write_register(input logic [alp_pkg::CFG_IW-1:0] idx,
                                  input logic [alp_pkg::CFG_DW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == alp_pkg::IDX_DEGREE) deg_reg = data[3:0];
        else if (idx == alp_pkg::IDX_ORDER) ord_reg = data[3:0];
    endtask

    // Changes degree and order only while the block is idle; upper data bits are noise.
    task automatic set_degree_order(input logic [3:0] l, input logic [3:0] m);
        drain_pipeline();
        write_register(alp_pkg::IDX_DEGREE, {$urandom(), 4'b0} | l);
        write_register(alp_pkg::IDX_ORDER, {$urandom(), 4'b0} | m);
        i_cfg_valid <= 1'b0;
    endtask

    // Sends one transaction, with a random idle gap first. Returns the predicted value.
    task automatic send_arg(input logic signed [alp_pkg::XW-1:0] x,
                            output logic signed [alp_pkg::VW-1:0] want);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_arg_x <= x;
        do @(posedge i_clk); while (o_stall);
        want = legendre_value(x);
        owed_values = {owed_values, want};
    endtask

    function automatic logic signed [alp_pkg::XW-1:0] random_arg();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'sd1073741824;
            2: return -32'sd1073741824;
            3: return '0;
            default: return $signed($urandom_range(0, 32'd2147483648)) - 32'sd1073741824;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed table: degree, order, argument, and a typed-in value where
    // it is obvious; other rows rely on the predictor alone.
    // ------------------------------------------------------------------
    typedef struct {
        logic [3:0]                    l;
        logic [3:0]                    m;
        logic signed [alp_pkg::XW-1:0] x;
        bit                            known;
        logic signed [alp_pkg::VW-1:0] value;
    } t_row;

    t_row table_rows[0:20] = '{
        // Register values right after reset: P_0^0 is one.
        '{4'd0, 4'd0, 32'sd123456789, 1'b1, alp_pkg::ONE_Q30},
        '{4'd0, 4'd0, 32'h8000_0000, 1'b1, alp_pkg::ONE_Q30},
        // First degree is x itself.
        '{4'd1, 4'd0, 32'sd1073741824, 1'b1, 56'sd1073741824},
        '{4'd1, 4'd0, -32'sd1073741824, 1'b1, -56'sd1073741824},
        '{4'd1, 4'd0, 32'sh7FFF_FFFF, 1'b1, 56'sd2147483647},
        '{4'd1, 4'd0, 32'h8000_0000, 1'b1, -56'sd2147483648},
        // P_1^1 is -sqrt(1 - x^2): zero at both ends, minus one at the middle.
        '{4'd1, 4'd1, 32'sd0, 1'b1, -56'sd1073741824},
        '{4'd1, 4'd1, 32'sd1073741824, 1'b1, 56'sd0},
        '{4'd1, 4'd1, -32'sd1073741824, 1'b1, 56'sd0},
        // Argument beyond one clamps the radicand to zero.
        '{4'd1, 4'd1, 32'sh7FFF_FFFF, 1'b1, 56'sd0},
        // Order above degree gives zero.
        '{4'd2, 4'd3, 32'sd536870912, 1'b1, 56'sd0},
        '{4'd0, 4'd15, 32'sh7FFF_FFFF, 1'b1, 56'sd0},
        // Degree above the maximum is clamped, so order 15 still exceeds it.
        '{4'd15, 4'd15, 32'sd0, 1'b1, 56'sd0},
        '{4'd15, 4'd0, 32'sd536870912, 1'b0, 56'sd0},
        '{4'd15, 4'd8, 32'sd0, 1'b0, 56'sd0},
        '{4'd8, 4'd8, 32'sd536870912, 1'b0, 56'sd0},
        '{4'd8, 4'd0, 32'sh7FFF_FFFF, 1'b0, 56'sd0},
        '{4'd8, 4'd0, 32'h8000_0000, 1'b0, 56'sd0},
        '{4'd8, 4'd7, 32'h8000_0000, 1'b0, 56'sd0},
        '{4'd5, 4'd2, -32'sd760000000, 1'b0, 56'sd0},
        '{4'd8, 4'd3, 32'sd1073741823, 1'b0, 56'sd0}
    };

    initial begin
        logic signed [alp_pkg::VW-1:0] want;
        int sent;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[r]) begin
            if (table_rows[r].l != deg_reg || table_rows[r].m != ord_reg)
                set_degree_order(table_rows[r].l, table_rows[r].m);
            send_arg(table_rows[r].x, want);
            if (table_rows[r].known && want !== table_rows[r].value)
                report_mismatch($sformatf("row %0d predicted %0d, table says %0d",
                                          r, want, table_rows[r].value));
        end

        // A write to an index past the two registers must change nothing.
        drain_pipeline();
        write_register(IDX_UNUSED, 32'hFFFF_FFFF);
        i_cfg_valid <= 1'b0;
        send_arg(32'sd300000000, want);

        // Random part in four idling phases, registers changed every few dozen items.
        sent = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            while (sent < N_RANDOM * (phase + 1) / 4) begin
                logic [3:0] l, m;
                if ((sent % 40) == 0) begin
                    l = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                                    : 4'($urandom_range(0, 8));
                    m = ($urandom_range(0, 5) == 0) ? 4'($urandom()) : 4'($urandom_range(0, l));
                    set_degree_order(l, m);
                end
                // Occasional runs with no gaps at all, even in the idling phases.
                if (send_idle_pct != 0 && $urandom_range(0, 19) == 0) begin
                    int keep;
                    keep = send_idle_pct;
                    send_idle_pct = 0;
                    send_arg(random_arg(), want);
                    send_idle_pct = keep;
                end else begin
                    send_arg(random_arg(), want);
                end
                sent++;
            end
        end

        drain_pipeline();
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
